// File: sv/gpio_controller_edge_detect_macros.svh
// assertion macros used by the checker file
`ifndef GPIO_CONTROLLER_EDGE_DETECT_MACROS_SVH
`define GPIO_CONTROLLER_EDGE_DETECT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gpio_ed_pkg.sv
package gpio_ed_pkg;

    localparam int DEF_NUM_PINS  = 54;
    localparam int PIN_PORT_W    = 54;
    localparam int BUS_W         = 32;
    localparam int WIDE_W        = 64;
    localparam int IDX_W         = 6;
    localparam int FSEL_WORDS    = 6;
    localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
    localparam int PINS_PER_WORD = 10;
    localparam int FSEL_BITS     = 3;
    localparam int FSEL_W        = PINS_PER_WORD * FSEL_BITS;
    localparam int FSEL_PINS     = FSEL_WORDS * PINS_PER_WORD;

    localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

    // beat kinds
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // register word map
    localparam logic [IDX_W-1:0] REG_SET_LO  = 6'd7;
    localparam logic [IDX_W-1:0] REG_SET_HI  = 6'd8;
    localparam logic [IDX_W-1:0] REG_CLR_LO  = 6'd10;
    localparam logic [IDX_W-1:0] REG_CLR_HI  = 6'd11;
    localparam logic [IDX_W-1:0] REG_LEV_LO  = 6'd13;
    localparam logic [IDX_W-1:0] REG_LEV_HI  = 6'd14;
    localparam logic [IDX_W-1:0] REG_EVT_LO  = 6'd16;
    localparam logic [IDX_W-1:0] REG_EVT_HI  = 6'd17;
    localparam logic [IDX_W-1:0] REG_REN_LO  = 6'd19;
    localparam logic [IDX_W-1:0] REG_REN_HI  = 6'd20;
    localparam logic [IDX_W-1:0] REG_FEN_LO  = 6'd22;
    localparam logic [IDX_W-1:0] REG_FEN_HI  = 6'd23;
    localparam logic [IDX_W-1:0] REG_AREN_LO = 6'd31;
    localparam logic [IDX_W-1:0] REG_AREN_HI = 6'd32;
    localparam logic [IDX_W-1:0] REG_AFEN_LO = 6'd34;
    localparam logic [IDX_W-1:0] REG_AFEN_HI = 6'd35;

    typedef struct packed {
        logic [1:0]            action;
        logic [IDX_W-1:0]      reg_index;
        logic [BUS_W-1:0]      write_data;
        logic [PIN_PORT_W-1:0] pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [BUS_W-1:0]      read_data;
        logic [PIN_PORT_W-1:0] pin_out;
        logic [PIN_PORT_W-1:0] pin_drive;
        logic                  event_pending;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } ged_cmd_t;

endpackage

// File: sv/gpio_controller_edge_detect.sv
// channel | signals                        | beat carries
// --------+--------------------------------+---------------------------------------
// in      | in_valid, in_ready, in_data    | bus read, bus write or pin sample tick
// out     | out_valid, out_ready, out_data | read word, latch, drive, event flag
//
// one beat in flight: accept, execute, then load the result register, in the order
// set by the controller sequence of idle, exec and emit states
// a stalled result holds in the result register; the next beat is still taken and
// executed, then waits to load and no further beat is taken until it does
// rst_n clears the register map and the controller state, every pin an input with no event pending
module gpio_controller_edge_detect
    import gpio_ed_pkg::*;
#(
    parameter int NUM_PINS = DEF_NUM_PINS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // load / execute / emit strobes from the controller
    ged_cmd_t cmd;

    // sequencing and result handshake
    gpio_ed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // register map, edge detect and result register
    gpio_ed_dp #(
        .NUM_PINS (NUM_PINS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// File: sv/gpio_ed_ctrl.sv
module gpio_ed_ctrl
    import gpio_ed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ged_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // result register is free when empty or drained this cycle
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign cmd.load = in_valid && in_ready;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.emit = emit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/gpio_ed_dp.sv
module gpio_ed_dp
    import gpio_ed_pkg::*;
#(
    parameter int NUM_PINS = DEF_NUM_PINS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ged_cmd_t  cmd,
    input  in_item_t  in_data,
    output out_item_t out_data
);

    typedef logic [NUM_PINS-1:0] pins_t;

    in_item_t          item_reg;
    logic [FSEL_W-1:0] fsel_reg  [FSEL_WORDS];
    logic [FSEL_W-1:0] fsel_next [FSEL_WORDS];
    pins_t             latch_reg, latch_next;
    pins_t             evt_reg, evt_next;
    pins_t             ren_reg, ren_next;
    pins_t             fen_reg, fen_next;
    pins_t             aren_reg, aren_next;
    pins_t             afen_reg, afen_next;
    pins_t             lev_reg, lev_next;
    logic [BUS_W-1:0]  rd_reg, rd_next;
    out_item_t         out_reg;
    pins_t             drive;
    pins_t             lev_in;
    pins_t             data_lo;
    pins_t             data_hi;
    logic [IDX_W-1:0]  idx;
    logic [BUS_W-1:0]  data;

    // one 32-bit half of a per-pin word
    function automatic logic [BUS_W-1:0] half_rd(pins_t v, logic hi);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return hi ? w[WIDE_W-1:BUS_W] : w[BUS_W-1:0];
    endfunction

    // replace one half, pins past the top drop out
    function automatic pins_t half_wr(pins_t v, logic [BUS_W-1:0] d, logic hi);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (hi)
        begin
            w[WIDE_W-1:BUS_W] = d;
        end
        else
        begin
            w[BUS_W-1:0] = d;
        end
        return NUM_PINS'(w);
    endfunction

    assign idx     = item_reg.reg_index;
    assign data    = item_reg.write_data;
    assign lev_in  = NUM_PINS'(WIDE_W'(item_reg.pin_levels));
    assign data_lo = NUM_PINS'(WIDE_W'(data));
    assign data_hi = NUM_PINS'({data, BUS_W'(0)});

    // output enable per pin from its function select
    for (genvar p = 0; p < NUM_PINS; p++)
    begin : g_drive
        if (p < FSEL_PINS)
        begin : g_fsel
            assign drive[p] = (fsel_reg[p / PINS_PER_WORD]
                [(p % PINS_PER_WORD) * FSEL_BITS +: FSEL_BITS] == FSEL_OUTPUT);
        end
        else
        begin : g_none
            assign drive[p] = 1'b0;
        end
    end

    always_comb
    begin
        fsel_next = fsel_reg;
        latch_next = latch_reg;
        evt_next   = evt_reg;
        ren_next   = ren_reg;
        fen_next   = fen_reg;
        aren_next  = aren_reg;
        afen_next  = afen_reg;
        lev_next   = lev_reg;
        rd_next    = rd_reg;
        if (cmd.exec)
        begin
            rd_next = '0;
            case (item_reg.action)
                ACT_READ:
                begin
                    case (idx)
                        REG_LEV_LO:  rd_next = half_rd(lev_reg, 1'b0);
                        REG_LEV_HI:  rd_next = half_rd(lev_reg, 1'b1);
                        REG_EVT_LO:  rd_next = half_rd(evt_reg, 1'b0);
                        REG_EVT_HI:  rd_next = half_rd(evt_reg, 1'b1);
                        REG_REN_LO:  rd_next = half_rd(ren_reg, 1'b0);
                        REG_REN_HI:  rd_next = half_rd(ren_reg, 1'b1);
                        REG_FEN_LO:  rd_next = half_rd(fen_reg, 1'b0);
                        REG_FEN_HI:  rd_next = half_rd(fen_reg, 1'b1);
                        REG_AREN_LO: rd_next = half_rd(aren_reg, 1'b0);
                        REG_AREN_HI: rd_next = half_rd(aren_reg, 1'b1);
                        REG_AFEN_LO: rd_next = half_rd(afen_reg, 1'b0);
                        REG_AFEN_HI: rd_next = half_rd(afen_reg, 1'b1);
                        default:
                        begin
                            if (idx < IDX_W'(FSEL_WORDS))
                            begin
                                rd_next = BUS_W'(fsel_reg[idx[FSEL_IDX_W-1:0]]);
                            end
                        end
                    endcase
                end
                ACT_WRITE:
                begin
                    case (idx)
                        REG_SET_LO:  latch_next = latch_reg | data_lo;
                        REG_SET_HI:  latch_next = latch_reg | data_hi;
                        REG_CLR_LO:  latch_next = latch_reg & ~data_lo;
                        REG_CLR_HI:  latch_next = latch_reg & ~data_hi;
                        REG_EVT_LO:  evt_next   = evt_reg & ~data_lo;
                        REG_EVT_HI:  evt_next   = evt_reg & ~data_hi;
                        REG_REN_LO:  ren_next   = half_wr(ren_reg, data, 1'b0);
                        REG_REN_HI:  ren_next   = half_wr(ren_reg, data, 1'b1);
                        REG_FEN_LO:  fen_next   = half_wr(fen_reg, data, 1'b0);
                        REG_FEN_HI:  fen_next   = half_wr(fen_reg, data, 1'b1);
                        REG_AREN_LO: aren_next  = half_wr(aren_reg, data, 1'b0);
                        REG_AREN_HI: aren_next  = half_wr(aren_reg, data, 1'b1);
                        REG_AFEN_LO: afen_next  = half_wr(afen_reg, data, 1'b0);
                        REG_AFEN_HI: afen_next  = half_wr(afen_reg, data, 1'b1);
                        default:
                        begin
                            if (idx < IDX_W'(FSEL_WORDS))
                            begin
                                fsel_next[idx[FSEL_IDX_W-1:0]] = data[FSEL_W-1:0];
                            end
                        end
                    endcase
                end
                ACT_TICK:
                begin
                    // sync and async enables act alike
                    evt_next = evt_reg
                        | (lev_in & ~lev_reg & (ren_reg | aren_reg))
                        | (lev_reg & ~lev_in & (fen_reg | afen_reg));
                    lev_next = lev_in;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg <= '0;
            evt_reg   <= '0;
            ren_reg   <= '0;
            fen_reg   <= '0;
            aren_reg  <= '0;
            afen_reg  <= '0;
            lev_reg   <= '0;
        end
        else
        begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
            evt_reg   <= evt_next;
            ren_reg   <= ren_next;
            fen_reg   <= fen_next;
            aren_reg  <= aren_next;
            afen_reg  <= afen_next;
            lev_reg   <= lev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.emit)
        begin
            out_reg.read_data     <= rd_reg;
            out_reg.pin_out       <= PIN_PORT_W'(WIDE_W'(latch_reg));
            out_reg.pin_drive     <= PIN_PORT_W'(WIDE_W'(drive));
            out_reg.event_pending <= |evt_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// File: sv/gpio_ed_chk.sv
`include "gpio_controller_edge_detect_macros.svh"

module gpio_ed_chk
    import gpio_ed_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `GED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
    `GED_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken while one is in flight")
    `GED_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result showed up the cycle after its beat")
    `GED_ASSERT_NOW(a_read_only_on_read, out_valid && !$past(out_valid) && $past(in_valid, 3) && $past(in_ready, 3) && ($past(in_data.action, 3) != ACT_READ), out_data.read_data == '0, "read data nonzero for a non-read beat")

endmodule

bind gpio_controller_edge_detect gpio_ed_chk u_chk (.*);

// File: test/gpio_controller_edge_detect_test.sv
module gpio_controller_edge_detect_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gpio_ed_pkg::*;

    // run shape
    localparam int RANDOM_BEATS  = 1350;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_EVERY   = 450;

    // action code the block treats as a no-op
    localparam logic [1:0] ACT_IDLE = 2'd3;

    // word indexes with no name in the package
    localparam logic [IDX_W-1:0] REG_FSEL_FIRST = '0;
    localparam logic [IDX_W-1:0] REG_FSEL_LAST  = IDX_W'(FSEL_WORDS - 1);
    localparam logic [IDX_W-1:0] REG_RESERVED   = 6'd6;
    localparam logic [IDX_W-1:0] REG_TOP        = 6'd63;

    localparam logic [63:0]           PIN_MASK = (64'd1 << DEF_NUM_PINS) - 64'd1;
    localparam logic [PIN_PORT_W-1:0] ALL_PINS = {PIN_PORT_W{1'b1}};
    localparam logic [BUS_W-1:0]      ALL_BITS = {BUS_W{1'b1}};

    // mapped words other than the function selects
    localparam logic [IDX_W-1:0] MAP_POOL [16] = '{
        REG_SET_LO, REG_SET_HI, REG_CLR_LO, REG_CLR_HI,
        REG_LEV_LO, REG_LEV_HI, REG_EVT_LO, REG_EVT_HI,
        REG_REN_LO, REG_REN_HI, REG_FEN_LO, REG_FEN_HI,
        REG_AREN_LO, REG_AREN_HI, REG_AFEN_LO, REG_AFEN_HI
    };

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // shadow of the register file, advanced once per accepted beat
    logic [FSEL_W-1:0] fsel_q [FSEL_WORDS] = '{default: '0};
    logic [63:0]       latch_q    = '0;
    logic [63:0]       status_q   = '0;
    logic [63:0]       rise_en_q  = '0;
    logic [63:0]       fall_en_q  = '0;
    logic [63:0]       arise_en_q = '0;
    logic [63:0]       afall_en_q = '0;
    logic [63:0]       levels_q   = '0;

    out_item_t awaited_results [$];
    stim_row_t directed_rows [$];
    int        errors      = 0;
    int        cycle_count = 0;

    // receiver stall pattern state
    rx_mode_t    rx_mode     = RX_STEADY;
    int          rx_left     = 0;
    logic [7:0]  rx_phase    = '0;

    gpio_controller_edge_detect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // lo or hi half of a per-pin word as seen on the bus
    function automatic logic [31:0] word_half(logic [63:0] v, logic hi);
        return hi ? v[63:32] : v[31:0];
    endfunction

    // bus word placed onto its pins, pins past the top masked off
    function automatic logic [63:0] half_word(logic [31:0] d, logic hi);
        return (hi ? {d, 32'h0} : {32'h0, d}) & PIN_MASK;
    endfunction

    // plain register write of one half, other half kept
    function automatic logic [63:0] merge_half(logic [63:0] old, logic [31:0] d, logic hi);
        logic [63:0] keep;
        keep = hi ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_0000_0000;
        return ((old & keep) | half_word(d, hi)) & PIN_MASK;
    endfunction

    // advance the shadow registers by one beat and return the result it must produce
    function automatic out_item_t apply_beat(in_item_t b);
        out_item_t   r;
        logic [63:0] lev;
        logic [63:0] rise;
        logic [63:0] fall;
        logic [63:0] drive;
        logic [FSEL_BITS-1:0] f;
        logic        hi;
        r = '0;
        case (b.action)
            ACT_READ:
            begin
                if (b.reg_index < FSEL_WORDS)
                    r.read_data = {{(BUS_W-FSEL_W){1'b0}}, fsel_q[b.reg_index[FSEL_IDX_W-1:0]]};
                else
                begin
                    case (b.reg_index)
                        REG_LEV_LO, REG_LEV_HI:
                            r.read_data = word_half(levels_q, b.reg_index == REG_LEV_HI);
                        REG_EVT_LO, REG_EVT_HI:
                            r.read_data = word_half(status_q, b.reg_index == REG_EVT_HI);
                        REG_REN_LO, REG_REN_HI:
                            r.read_data = word_half(rise_en_q, b.reg_index == REG_REN_HI);
                        REG_FEN_LO, REG_FEN_HI:
                            r.read_data = word_half(fall_en_q, b.reg_index == REG_FEN_HI);
                        REG_AREN_LO, REG_AREN_HI:
                            r.read_data = word_half(arise_en_q, b.reg_index == REG_AREN_HI);
                        REG_AFEN_LO, REG_AFEN_HI:
                            r.read_data = word_half(afall_en_q, b.reg_index == REG_AFEN_HI);
                        default:
                            r.read_data = '0;
                    endcase
                end
            end
            ACT_WRITE:
            begin
                if (b.reg_index < FSEL_WORDS)
                    fsel_q[b.reg_index[FSEL_IDX_W-1:0]] = b.write_data[FSEL_W-1:0];
                else
                begin
                    case (b.reg_index)
                        REG_SET_HI, REG_CLR_HI, REG_EVT_HI, REG_REN_HI,
                        REG_FEN_HI, REG_AREN_HI, REG_AFEN_HI: hi = 1'b1;
                        default: hi = 1'b0;
                    endcase
                    case (b.reg_index)
                        REG_SET_LO, REG_SET_HI:
                            latch_q = latch_q | half_word(b.write_data, hi);
                        REG_CLR_LO, REG_CLR_HI:
                            latch_q = latch_q & ~half_word(b.write_data, hi);
                        REG_EVT_LO, REG_EVT_HI:
                            status_q = status_q & ~half_word(b.write_data, hi);
                        REG_REN_LO, REG_REN_HI:
                            rise_en_q = merge_half(rise_en_q, b.write_data, hi);
                        REG_FEN_LO, REG_FEN_HI:
                            fall_en_q = merge_half(fall_en_q, b.write_data, hi);
                        REG_AREN_LO, REG_AREN_HI:
                            arise_en_q = merge_half(arise_en_q, b.write_data, hi);
                        REG_AFEN_LO, REG_AFEN_HI:
                            afall_en_q = merge_half(afall_en_q, b.write_data, hi);
                        default: ;
                    endcase
                end
            end
            ACT_TICK:
            begin
                // both edge sets count the same way
                lev  = {{(64-PIN_PORT_W){1'b0}}, b.pin_levels} & PIN_MASK;
                rise = lev & ~levels_q;
                fall = levels_q & ~lev;
                status_q = (status_q | (rise & (rise_en_q | arise_en_q))
                                     | (fall & (fall_en_q | afall_en_q))) & PIN_MASK;
                levels_q = lev;
            end
            default: ;
        endcase
        drive = '0;
        for (int p = 0; p < FSEL_PINS && p < DEF_NUM_PINS; p++)
        begin
            f = fsel_q[p / PINS_PER_WORD][(p % PINS_PER_WORD) * FSEL_BITS +: FSEL_BITS];
            if (f == FSEL_OUTPUT)
                drive[p] = 1'b1;
        end
        r.pin_out       = latch_q[PIN_PORT_W-1:0];
        r.pin_drive     = drive[PIN_PORT_W-1:0];
        r.event_pending = (status_q != 64'd0);
        return r;
    endfunction

    // rows with a typed result all come before any latch or select write,
    // so only the read word can be nonzero there
    function automatic void add_row(logic [1:0] act, logic [IDX_W-1:0] idx,
                                    logic [BUS_W-1:0] data, logic [PIN_PORT_W-1:0] lev,
                                    bit typed, logic [BUS_W-1:0] typed_read);
        stim_row_t row;
        row.beat   = '{action: act, reg_index: idx, write_data: data, pin_levels: lev};
        row.typed  = typed;
        row.result = '{read_data: typed_read, pin_out: '0, pin_drive: '0, event_pending: 1'b0};
        directed_rows.push_back(row);
    endfunction

    // random beat, mostly mapped words, with some unmapped and no-op noise
    function automatic in_item_t random_beat();
        in_item_t    b;
        int          pick;
        logic [63:0] flip;
        logic [63:0] lev;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            b.action = ACT_READ;
        else if (pick < 58)
            b.action = ACT_WRITE;
        else if (pick < 96)
            b.action = ACT_TICK;
        else
            b.action = ACT_IDLE;

        pick = $urandom_range(0, 99);
        if (pick < 25)
            b.reg_index = IDX_W'($urandom_range(0, FSEL_WORDS - 1));
        else if (pick < 88)
            b.reg_index = MAP_POOL[$urandom_range(0, 15)];
        else
            b.reg_index = IDX_W'($urandom_range(0, 63));

        case ($urandom_range(0, 9))
            0: b.write_data = '0;
            1: b.write_data = ALL_BITS;
            2: b.write_data = 32'h1 << $urandom_range(0, 31);
            default: b.write_data = $urandom;
        endcase

        // levels: four in ten samples toggle one to three pins from the last, giving sparse edges
        case ($urandom_range(0, 9))
            0: b.pin_levels = '0;
            1: b.pin_levels = ALL_PINS;
            2, 3, 4, 5:
            begin
                flip = '0;
                repeat ($urandom_range(1, 3))
                    flip[$urandom_range(0, DEF_NUM_PINS - 1)] = 1'b1;
                lev = levels_q ^ flip;
                b.pin_levels = lev[PIN_PORT_W-1:0];
            end
            default:
            begin
                lev = {$urandom, $urandom};
                b.pin_levels = lev[PIN_PORT_W-1:0];
            end
        endcase
        return b;
    endfunction

    // hold the beat until accepted, then queue what it must produce
    task automatic send_beat(input in_item_t b, input bit typed, input out_item_t typed_result);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_beat(b);
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result beat with nothing awaited: %p", got);
            errors++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data expected %h actual %h", want.read_data, got.read_data);
                errors++;
            end
            if (got.pin_out !== want.pin_out)
            begin
                $error("pin_out expected %h actual %h", want.pin_out, got.pin_out);
                errors++;
            end
            if (got.pin_drive !== want.pin_drive)
            begin
                $error("pin_drive expected %h actual %h", want.pin_drive, got.pin_drive);
                errors++;
            end
            if (got.event_pending !== want.event_pending)
            begin
                $error("event_pending expected %b actual %b",
                       want.event_pending, got.event_pending);
                errors++;
            end
        end
    endtask

    // result side: every accepted beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
    end

    // receiver stalls: random stall modes in turn, steady mode gives clean stretches
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_STEADY: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_phase[1:0] == 2'b11);
            default:   out_ready <= rx_phase[2];
        endcase
        rx_phase <= rx_phase + 8'd1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results awaited",
                   cycle_count, awaited_results.size());
            $display("gpio_controller_edge_detect_test failed");
            $finish;
        end
    end

    initial
    begin
        int  sent;
        int  burst;
        int  gap;
        int  next_drain;
        int  waited;
        bit  drain_now;

        // reset is released once, at a rising edge
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: reset state, extremes, unmapped words, no-op, edges
        add_row(ACT_READ,  REG_EVT_LO,     ALL_BITS,      ALL_PINS, 1, 32'h0);
        add_row(ACT_READ,  REG_FSEL_FIRST, 32'h0,         '0,       1, 32'h0);
        add_row(ACT_READ,  REG_TOP,        32'h0,         '0,       1, 32'h0);
        add_row(ACT_IDLE,  REG_SET_LO,     ALL_BITS,      ALL_PINS, 1, 32'h0);
        // first tick compares against all-zero levels, nothing enabled yet
        add_row(ACT_TICK,  REG_SET_HI,     ALL_BITS,      ALL_PINS, 1, 32'h0);
        add_row(ACT_READ,  REG_LEV_LO,     32'h0,         '0,       1, 32'hFFFF_FFFF);
        add_row(ACT_READ,  REG_LEV_HI,     32'h0,         '0,       1, 32'h003F_FFFF);
        add_row(ACT_WRITE, REG_RESERVED,   ALL_BITS,      '0,       1, 32'h0);
        add_row(ACT_WRITE, REG_LEV_LO,     32'h0,         '0,       1, 32'h0);
        // from here on the predictor supplies the result
        add_row(ACT_WRITE, REG_FSEL_FIRST, ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_FSEL_LAST,  32'h0924_9249, '0,       0, 32'h0);
        add_row(ACT_READ,  REG_FSEL_LAST,  32'h0,         '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_SET_LO,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_SET_HI,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_CLR_LO,     32'h5555_5555, '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_REN_LO,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_FEN_HI,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_AREN_HI,    32'hFFFF_0000, '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_AFEN_LO,    32'h0000_FFFF, '0,       0, 32'h0);
        add_row(ACT_TICK,  REG_TOP,        32'h0,         '0,       0, 32'h0);
        add_row(ACT_TICK,  REG_TOP,        32'h0,         ALL_PINS, 0, 32'h0);
        add_row(ACT_READ,  REG_EVT_LO,     32'h0,         '0,       0, 32'h0);
        add_row(ACT_READ,  REG_EVT_HI,     32'h0,         '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_EVT_LO,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_WRITE, REG_EVT_HI,     ALL_BITS,      '0,       0, 32'h0);
        add_row(ACT_READ,  REG_AREN_HI,    32'h0,         '0,       0, 32'h0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

        // random part: bursts of beats with random gaps, occasional full drain
        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                send_beat(random_beat(), 1'b0, '0);
                sent++;
            end
            gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            drain_now = (sent >= next_drain);
            // valid drops only where it is not raised again in the same step
            if (gap > 0 || drain_now || sent == RANDOM_BEATS)
                in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
            if (drain_now)
            begin
                // sender holds off until every result is back
                while (awaited_results.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                next_drain += DRAIN_EVERY;
            end
        end

        // wait out the tail, then settle to catch any stray beat
        waited = 0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            errors++;
        end
        if (errors == 0)
            $display("gpio_controller_edge_detect_test passed");
        else
            $display("gpio_controller_edge_detect_test failed");
        $finish;
    end

endmodule

// File: gpio_controller_edge_detect.f
+incdir+sv
sv/gpio_ed_pkg.sv
sv/gpio_ed_ctrl.sv
sv/gpio_ed_dp.sv
sv/gpio_controller_edge_detect.sv
sv/gpio_ed_chk.sv
test/gpio_controller_edge_detect_test.sv
